### sv/sbwb_pkg.sv
// Shared constants, types and window table for the spectral bin window blur.
package sbwb_pkg;

  localparam int WEIGHT_LEN  = 256;
  localparam int MAX_RANGE   = 64;
  localparam int MAX_FRAME   = 1024;
  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_SHAPES  = 5;
  localparam int IW          = $clog2(WEIGHT_LEN);
  localparam int RW          = $clog2(MAX_RANGE + 1);
  localparam int DW          = $clog2(2 * MAX_RANGE + 1);
  localparam int SHW         = 3;
  localparam int ACC_W       = 40;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int WT_W        = 17;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLUR_RANGE   = 3'd0,
    REG_WINDOW_SHAPE = 3'd1,
    REG_FRAME_SIZE   = 3'd2,
    REG_AMP_ENABLE   = 3'd3,
    REG_PHASE_ENABLE = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_LOOK,
    ST_MIX,
    ST_WSUM,
    ST_SCALE,
    ST_ACC,
    ST_OUT_RD,
    ST_OUT_WR
  } back_state_e;

  typedef struct packed {
    logic [RW-1:0]  blur_range;
    logic [SHW-1:0] window_shape;
  } cfg_t;

  typedef logic [NUM_SHAPES*WEIGHT_LEN-1:0][WT_W-1:0] wrom_t;

  function automatic logic [63:0] div_small(input logic [63:0] t, input logic [6:0] k);
    logic [63:0] q;
    case (k)
      7'd1:    q = t;
      7'd2:    q = t / 2;
      7'd3:    q = t / 3;
      7'd4:    q = t / 4;
      7'd5:    q = t / 5;
      7'd6:    q = t / 6;
      7'd7:    q = t / 7;
      7'd8:    q = t / 8;
      7'd9:    q = t / 9;
      7'd10:   q = t / 10;
      7'd11:   q = t / 11;
      7'd12:   q = t / 12;
      7'd30:   q = t / 30;
      7'd56:   q = t / 56;
      7'd90:   q = t / 90;
      default: q = t;
    endcase
    return q;
  endfunction

  function automatic logic [6:0] cos_div(input int k);
    logic [6:0] d;
    case (k)
      0:       d = 7'd90;
      1:       d = 7'd56;
      2:       d = 7'd30;
      3:       d = 7'd12;
      default: d = 7'd2;
    endcase
    return d;
  endfunction

  function automatic logic [63:0] expneg_q30(input logic [63:0] z);
    logic [63:0] r;
    logic [63:0] t;
    r = ONE_Q30;
    for (int k = 12; k >= 1; k--) begin
      t = div_small((z * r) >> 30, 7'(k));
      r = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    end
    return r;
  endfunction

  function automatic logic [63:0] cos_q30(input logic [63:0] v);
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] t;
    a = (v * 64'd1686629713) >> 16;
    s = (a * a) >> 30;
    r = ONE_Q30;
    for (int k = 0; k < 5; k++) begin
      t = div_small((s * r) >> 30, cos_div(k));
      r = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    end
    return r;
  endfunction

  function automatic logic [63:0] to_q16(input logic [63:0] r);
    logic [63:0] q;
    q = (r + 64'd8192) >> 14;
    return (q > 64'd65536) ? 64'd65536 : q;
  endfunction

  function automatic wrom_t build_wrom();
    wrom_t       w;
    logic [63:0] ad;
    logic [63:0] v;
    logic [63:0] e;
    logic [63:0] c;
    logic [63:0] rc;
    logic [63:0] u2;
    logic [63:0] u4;
    for (int i = 0; i < WEIGHT_LEN; i++) begin
      ad = (2 * i >= WEIGHT_LEN - 1) ? 64'(2 * i - (WEIGHT_LEN - 1))
                                     : 64'((WEIGHT_LEN - 1) - 2 * i);
      v  = (ad * 64'd65536 + 64'((WEIGHT_LEN - 1) / 2)) / 64'(WEIGHT_LEN - 1);
      if (v > 64'd65536) v = 64'd65536;
      e = expneg_q30((v * v * 64'd25) >> 7);
      for (int k = 0; k < 3; k++) e = (e * e + (64'd1 << 29)) >> 30;
      w[i] = WT_W'(to_q16(e));
      w[WEIGHT_LEN + i] = WT_W'(64'd65536 - v);
      c  = cos_q30(v);
      rc = (c * c + (64'd1 << 43)) >> 44;
      if (rc > 64'd65536) rc = 64'd65536;
      w[2 * WEIGHT_LEN + i] = WT_W'(rc);
      w[3 * WEIGHT_LEN + i] = WT_W'(to_q16(c));
      u2 = (v * v + 64'd32768) >> 16;
      u4 = (u2 * u2 + 64'd32768) >> 16;
      if (u4 > 64'd65536) u4 = 64'd65536;
      w[4 * WEIGHT_LEN + i] = WT_W'(64'd65536 - u4);
    end
    return w;
  endfunction

  localparam wrom_t WROM = build_wrom();

endpackage

### sv/sbwb_front.sv
// Input side: accepts bins, tracks frame position and bank, queues work items.
module sbwb_front import sbwb_pkg::*; #(
  parameter int MaxFrame = MAX_FRAME
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [2*DATA_W-1:0]                 s_tdata_i,
  input  logic                                amp_en_i,
  input  logic                                ph_en_i,
  input  logic [$clog2(MaxFrame+1)-1:0]       frame_i,
  input  logic                                frame_wr_i,
  input  logic                                block_i,
  input  logic                                full_i,
  output logic                                push_o,
  output logic [2*DATA_W+$clog2(MaxFrame)+1:0] item_o
);

  localparam int AW = $clog2(MaxFrame);
  localparam int FW = $clog2(MaxFrame + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] amp;
    logic signed [DATA_W-1:0] ph;
    logic [AW-1:0]            bin;
    logic                     bank;
    logic                     last;
  } item_t;

  logic [AW-1:0] pos_q, pos_d;
  logic          bank_q, bank_d;
  logic [FW-1:0] fm1;
  logic          last;
  item_t         item;

  assign s_tready_o = !full_i && !block_i;
  assign push_o     = s_tvalid_i && s_tready_o;
  assign fm1        = frame_i - FW'(1);
  assign last       = (FW'(pos_q) == fm1);

  always_comb begin
    item.amp  = amp_en_i ? s_tdata_i[DATA_W-1:0] : '0;
    item.ph   = ph_en_i  ? s_tdata_i[2*DATA_W-1:DATA_W] : '0;
    item.bin  = AW'(fm1 - FW'(pos_q));
    item.bank = bank_q;
    item.last = last;
    pos_d     = pos_q;
    bank_d    = bank_q;
    if (frame_wr_i) begin
      pos_d = '0;
    end else if (push_o) begin
      if (last) begin
        pos_d  = '0;
        bank_d = !bank_q;
      end else begin
        pos_d = pos_q + AW'(1);
      end
    end
  end

  assign item_o = item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      bank_q <= bank_d;
    end
  end

endmodule

### sv/sbwb_fifo.sv
// Short request queue between the front and the back.
module sbwb_fifo import sbwb_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wp_q, rp_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PW'(Depth - 1)) ? '0 : wp_q + PW'(1);
      if (pop_i)  rp_q <= (rp_q == PW'(Depth - 1)) ? '0 : rp_q + PW'(1);
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

### sv/sbwb_back.sv
// Work side: weight interpolation, scatter-add into the write bank, readout and clear.
module sbwb_back import sbwb_pkg::*; #(
  parameter int MaxFrame = MAX_FRAME
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cfg_t                                 cfg_i,
  input  logic [$clog2(MaxFrame+1)-1:0]        frame_i,
  input  logic                                 clear_i,
  input  logic                                 q_valid_i,
  input  logic [2*DATA_W+$clog2(MaxFrame)+1:0] q_data_i,
  output logic                                 q_pop_o,
  output logic                                 busy_o,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [2*DATA_W-1:0]                  m_tdata_o,
  output logic                                 m_tlast_o
);

  localparam int AW  = $clog2(MaxFrame);
  localparam int FW  = $clog2(MaxFrame + 1);
  localparam int MD  = 2 ** (AW + 1);
  localparam int JW  = ((AW > RW) ? AW : RW) + 2;
  localparam int NW  = IW + 16;
  localparam int DCW = $clog2(NW + 1);
  localparam int SAW = $clog2(NUM_SHAPES * WEIGHT_LEN);
  localparam int PW  = DATA_W + WT_W + 1;
  localparam int CAW = PW - 16;
  localparam logic [NW-1:0] NUM = NW'(WEIGHT_LEN - 1) << 16;

  typedef struct packed {
    logic signed [DATA_W-1:0] amp;
    logic signed [DATA_W-1:0] ph;
    logic [AW-1:0]            bin;
    logic                     bank;
    logic                     last;
  } item_t;

  item_t       it;
  back_state_e state_q, state_d;
  logic [AW:0] clr_q, clr_d;
  logic        out_vq, out_vd;

  logic [NW-1:0]  num_q, num_d, quo_q, quo_d;
  logic [DW-1:0]  drem_q, drem_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic [IW-1:0]  q0_q, q0_d;
  logic [15:0]    f0_q, f0_d;
  logic [DW-1:0]  g0_q, g0_d, r0_q, r0_d;
  logic [IW:0]    idx_q, idx_d;
  logic [DW-1:0]  rem_q, rem_d, fr_q, fr_d, k_q, k_d;
  logic [15:0]    fq_q, fq_d;
  logic signed [JW-1:0] j_q, j_d;

  logic [WT_W-1:0]       w0_q, w1_q, w_q;
  logic [2*WT_W-1:0]     m1_q, m2_q;
  logic signed [PW-1:0]  pa_q, pp_q;
  logic signed [ACC_W-1:0] rda_q, rdp_q;
  logic [DATA_W-1:0]     oa_q, op_q;
  logic                  ol_q;

  logic signed [ACC_W-1:0] mem_a [MD];
  logic signed [ACC_W-1:0] mem_p [MD];

  logic              we, re, load_out;
  logic [AW:0]       wa, ra;
  logic signed [ACC_W-1:0] wda, wdp;

  logic [RW-1:0]   rr;
  logic [DW-1:0]   dd;
  logic [DW:0]     sh;
  logic            ge, inr, fc, rc, last_off;
  logic [DW:0]     fr_sum, rem_sum;
  logic [17:0]     fq_sum;
  logic [IW+DW-1:0] prod;
  logic [IW-1:0]   ic, nx;
  logic [SAW-1:0]  a0, a1;
  logic [2*WT_W:0] wsum;
  logic signed [CAW-1:0] ca_a, ca_p;
  logic signed [ACC_W:0] sa, sp;
  logic signed [ACC_W-1:0] na, np;

  function automatic logic signed [ACC_W-1:0] sat40(input logic signed [ACC_W:0] s);
    logic signed [ACC_W-1:0] r;
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else begin
      r = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign it     = item_t'(q_data_i);
  assign busy_o = (state_q == ST_CLEAR);
  assign rr     = (cfg_i.blur_range == '0) ? RW'(1) : cfg_i.blur_range;
  assign dd     = DW'({rr, 1'b0});

  assign sh   = {drem_q, num_q[NW-1]};
  assign ge   = (sh >= (DW + 1)'(dd));
  assign prod = (IW + DW)'(quo_q[NW-1:16]) * (IW + DW)'(dd);

  assign inr      = !j_q[JW-1] && (j_q < JW'(frame_i));
  assign last_off = (k_q == DW'({cfg_i.blur_range, 1'b0}));

  assign fr_sum  = {1'b0, fr_q} + {1'b0, g0_q};
  assign fc      = (fr_sum >= (DW + 1)'(dd));
  assign rem_sum = {1'b0, rem_q} + {1'b0, r0_q};
  assign rc      = (rem_sum >= (DW + 1)'(dd));
  assign fq_sum  = {2'b0, fq_q} + {2'b0, f0_q} + 18'(fc);

  assign ic = (idx_q > (IW + 1)'(WEIGHT_LEN - 1)) ? IW'(WEIGHT_LEN - 1) : idx_q[IW-1:0];
  assign nx = (ic == IW'(WEIGHT_LEN - 1)) ? ic : ic + IW'(1);
  assign a0 = SAW'(cfg_i.window_shape) * SAW'(WEIGHT_LEN) + SAW'(ic);
  assign a1 = SAW'(cfg_i.window_shape) * SAW'(WEIGHT_LEN) + SAW'(nx);

  assign wsum = (2 * WT_W + 1)'(m1_q) + (2 * WT_W + 1)'(m2_q) + (2 * WT_W + 1)'(32768);

  assign ca_a = CAW'((pa_q + PW'(32768)) >>> 16);
  assign ca_p = CAW'((pp_q + PW'(32768)) >>> 16);
  assign sa   = (ACC_W + 1)'(rda_q) + (ACC_W + 1)'(ca_a);
  assign sp   = (ACC_W + 1)'(rdp_q) + (ACC_W + 1)'(ca_p);
  assign na   = sat40(sa);
  assign np   = sat40(sp);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    num_d    = num_q;
    quo_d    = quo_q;
    drem_d   = drem_q;
    dcnt_d   = dcnt_q;
    q0_d     = q0_q;
    f0_d     = f0_q;
    g0_d     = g0_q;
    r0_d     = r0_q;
    idx_d    = idx_q;
    rem_d    = rem_q;
    fr_d     = fr_q;
    fq_d     = fq_q;
    k_d      = k_q;
    j_d      = j_q;
    we       = 1'b0;
    wa       = clr_q;
    wda      = '0;
    wdp      = '0;
    re       = 1'b0;
    ra       = {!it.bank, j_q[AW-1:0]};
    load_out = 1'b0;
    q_pop_o  = 1'b0;
    out_vd   = out_vq && !m_tready_i;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + (AW + 1)'(1);
        if (&clr_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          num_d   = NUM;
          quo_d   = '0;
          drem_d  = '0;
          dcnt_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        drem_d = ge ? DW'(sh - (DW + 1)'(dd)) : DW'(sh);
        quo_d  = {quo_q[NW-2:0], ge};
        num_d  = {num_q[NW-2:0], 1'b0};
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(NW - 1)) state_d = ST_PREP;
      end
      ST_PREP: begin
        q0_d = quo_q[NW-1:16];
        f0_d = quo_q[15:0];
        g0_d = drem_q;
        r0_d = DW'((IW + DW)'(WEIGHT_LEN - 1) - prod);
        if (cfg_i.blur_range == '0) begin
          idx_d = (IW + 1)'(quo_q[NW-1:16]);
          rem_d = r0_d;
          fq_d  = quo_q[15:0];
          fr_d  = drem_q;
        end else begin
          idx_d = '0;
          rem_d = '0;
          fq_d  = '0;
          fr_d  = '0;
        end
        k_d     = '0;
        j_d     = JW'(it.bin) - JW'(cfg_i.blur_range);
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        re      = 1'b1;
        state_d = ST_MIX;
      end
      ST_MIX:   state_d = ST_WSUM;
      ST_WSUM:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_ACC;
      ST_ACC: begin
        we    = inr;
        wa    = {!it.bank, j_q[AW-1:0]};
        wda   = na;
        wdp   = np;
        fr_d  = fc ? DW'(fr_sum - (DW + 1)'(dd)) : DW'(fr_sum);
        rem_d = rc ? DW'(rem_sum - (DW + 1)'(dd)) : DW'(rem_sum);
        fq_d  = rc ? 16'(fq_sum - 18'h10000) : fq_sum[15:0];
        idx_d = idx_q + (IW + 1)'(q0_q) + (IW + 1)'(rc);
        k_d   = k_q + DW'(1);
        j_d   = j_q + JW'(1);
        state_d = last_off ? ST_OUT_RD : ST_LOOK;
      end
      ST_OUT_RD: begin
        re      = 1'b1;
        ra      = {it.bank, it.bin};
        state_d = ST_OUT_WR;
      end
      ST_OUT_WR: begin
        if (!out_vq || m_tready_i) begin
          load_out = 1'b1;
          out_vd   = 1'b1;
          we       = 1'b1;
          wa       = {it.bank, it.bin};
          q_pop_o  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (clear_i) begin
      state_d = ST_CLEAR;
      clr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      out_vq  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      out_vq  <= out_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quo_q  <= quo_d;
    drem_q <= drem_d;
    dcnt_q <= dcnt_d;
    q0_q   <= q0_d;
    f0_q   <= f0_d;
    g0_q   <= g0_d;
    r0_q   <= r0_d;
    idx_q  <= idx_d;
    rem_q  <= rem_d;
    fr_q   <= fr_d;
    fq_q   <= fq_d;
    k_q    <= k_d;
    j_q    <= j_d;
    if (state_q == ST_LOOK) begin
      w0_q <= WROM[a0];
      w1_q <= WROM[a1];
    end
    if (state_q == ST_MIX) begin
      m1_q <= w0_q * (WT_W'(65536) - WT_W'(fq_q));
      m2_q <= w1_q * WT_W'(fq_q);
    end
    if (state_q == ST_WSUM) w_q <= WT_W'(wsum >> 16);
    if (state_q == ST_SCALE) begin
      pa_q <= PW'(it.amp) * signed'({1'b0, w_q});
      pp_q <= PW'(it.ph) * signed'({1'b0, w_q});
    end
    if (load_out) begin
      oa_q <= sat32(rda_q);
      op_q <= sat32(rdp_q);
      ol_q <= it.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_a[wa] <= wda;
      mem_p[wa] <= wdp;
    end
    if (re) begin
      rda_q <= mem_a[ra];
      rdp_q <= mem_p[ra];
    end
  end

  assign m_tvalid_o = out_vq;
  assign m_tdata_o  = {op_q, oa_q};
  assign m_tlast_o  = ol_q;

endmodule

### sv/spectral_bin_window_blur_core.sv
// Top level of the spectral bin window blur: configuration registers and block wiring.
//
// Each accepted bin is scattered into its 2*blur_range+1 neighbors of the write bank and the
// same bin of the previous frame is emitted and cleared. For one bin, a bit-serial divide
// sets up the weight interpolation, then a read-modify-write pass per neighbor (LOOK, MIX, WSUM,
// SCALE, ACC) on the accumulator memory, then a readout. After reset and after every
// frame_size write a clearing pass zeroes both banks; no bin is accepted during it. A
// two-entry queue and an output register let input and output stall independently.
module spectral_bin_window_blur_core import sbwb_pkg::*; #(
  parameter int MaxFrame = MAX_FRAME
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [2*DATA_W-1:0]  s_axis_tdata,  // amp_in, phase_in
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*DATA_W-1:0]  m_axis_tdata,  // amp_out, phase_out
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int AW    = $clog2(MaxFrame);
  localparam int FW    = $clog2(MaxFrame + 1);
  localparam int ItemW = 2 * DATA_W + AW + 2;

  cfg_t          cfg_q;
  logic [FW-1:0] frame_q;
  logic          amp_en_q, ph_en_q;
  logic          frame_wr, push, full, pop, qvalid, busy;
  logic [ItemW-1:0] item_in, item_out;

  assign frame_wr = cfg_we_i && (cfg_idx_i == REG_FRAME_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blur_range   <= RW'(2);
      cfg_q.window_shape <= '0;
      frame_q            <= FW'(MaxFrame);
      amp_en_q           <= 1'b1;
      ph_en_q            <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLUR_RANGE: begin
          cfg_q.blur_range <= (int'(cfg_wdata_i[6:0]) > MAX_RANGE) ? RW'(MAX_RANGE)
                                                                 : RW'(cfg_wdata_i[6:0]);
        end
        REG_WINDOW_SHAPE: begin
          if (int'(cfg_wdata_i[SHW-1:0]) < NUM_SHAPES) cfg_q.window_shape <= cfg_wdata_i[SHW-1:0];
        end
        REG_FRAME_SIZE: begin
          if (cfg_wdata_i == '0) begin
            frame_q <= FW'(1);
          end else if (int'(cfg_wdata_i) > MaxFrame) begin
            frame_q <= FW'(MaxFrame);
          end else begin
            frame_q <= FW'(cfg_wdata_i);
          end
        end
        REG_AMP_ENABLE:   amp_en_q <= cfg_wdata_i[0];
        REG_PHASE_ENABLE: ph_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  sbwb_front #(.MaxFrame(MaxFrame)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .amp_en_i   (amp_en_q),
    .ph_en_i    (ph_en_q),
    .frame_i    (frame_q),
    .frame_wr_i (frame_wr),
    .block_i    (busy),
    .full_i     (full),
    .push_o     (push),
    .item_o     (item_in)
  );

  sbwb_fifo #(.Width(ItemW), .Depth(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .data_o  (item_out)
  );

  sbwb_back #(.MaxFrame(MaxFrame)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .frame_i    (frame_q),
    .clear_i    (frame_wr),
    .q_valid_i  (qvalid),
    .q_data_i   (item_out),
    .q_pop_o    (pop),
    .busy_o     (busy),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

### sv/sbwb_checker.sv
// Port-level checks for the spectral bin window blur core, bound to the top level.
module sbwb_checker import sbwb_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [2*DATA_W-1:0]  m_axis_tdata,
  input logic                 m_axis_tlast,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i
);

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid && !s_axis_tready)
    else $error("request or result seen right after reset");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == REG_FRAME_SIZE) |=> !s_axis_tready)
    else $error("request taken during bank clear");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind spectral_bin_window_blur_core sbwb_checker u_sbwb_checker (.*);
